// ===== design/crt_congruence_merge_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the congruence merge block
// Implication checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef CRT_CONGRUENCE_MERGE_MACROS_SVH
`define CRT_CONGRUENCE_MERGE_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== design/crt_pkg.sv =====
// ----------------------------------------------------------------------------
// Congruence merge package
// Shared widths, state and status codes, and the divider request type.
// ----------------------------------------------------------------------------
package crt_pkg;

  localparam int DATA_W           = 63;
  localparam int CNT_W            = 6;
  localparam int FIELD_W          = 16;
  localparam int MODULUS_BITS_DEF = 16;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOSOL = 2'd1,
    ST_OVF   = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_RED, S_AMOD, S_RMOD, S_EU_CHK, S_EU_DIV, S_EU_MUL, S_CDIV,
    S_SDIV, S_LCM, S_INV, S_TMUL, S_TSTART, S_TDIV, S_RES
  } state_e;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] nbits;
  } div_req_t;

endpackage

// ===== design/crt_congruence_merge.sv =====
// ----------------------------------------------------------------------------
// Congruence merge (generalized Chinese remainder)
// Merges x = residue (mod modulus) into a running congruence, one per item.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid_i/in_stall_o   modulus_i, residue_i, first_item_i
//   out      output     out_valid_o/out_stall_i merged_residue_o, merged_modulus_o,
//                                               status_o
//
// A first item or an item after a sticky error only reduces its residue. A
// merge runs the steps below, each division on the shared bit-serial
// divider, one quotient bit per cycle.
// Reset gives x = 0 (mod 1) with consistent status. A result stays on the
// outputs until transferred; no new item is taken until then.
//
// Every item first reduces its residue modulo its modulus. A merge then takes
// the running modulus and residue modulo m, runs extended Euclid with signed
// coefficients to get g and the coefficient of the running modulus, checks
// that g divides the residue difference, forms lcm = run_modulus * (m/g) with
// a shift-add multiplier (its upper bits flag overflow), and finally adds
// t * run_modulus to the running residue, t being the step solution mod m/g.
module crt_congruence_merge #(
  parameter int MODULUS_BITS = crt_pkg::MODULUS_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [crt_pkg::FIELD_W-1:0] modulus_i,
  input  logic [crt_pkg::FIELD_W-1:0] residue_i,
  input  logic                        first_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [crt_pkg::DATA_W-1:0]  merged_residue_o,
  output logic [crt_pkg::DATA_W-1:0]  merged_modulus_o,
  output logic [1:0]                  status_o
);

  localparam int MB   = MODULUS_BITS;
  localparam int DW   = crt_pkg::DATA_W;
  localparam int CW   = crt_pkg::CNT_W;
  localparam int FW   = crt_pkg::FIELD_W;
  localparam int IN_W = (MB < FW) ? MB : FW;
  localparam int SW   = MB + 2;
  localparam int PW   = DW + MB;
  localparam int MC_W = $clog2(MB);

  crt_pkg::state_e  state_q, state_d;
  crt_pkg::status_e status_q;

  logic            out_valid_q, accept, fin;
  logic [MB-1:0]   m_q, r_q, r0_q, r1_q, q_q, tr_q, c_q, cq_q, s_q, inv_q;
  logic            first_q;
  logic signed [SW-1:0] s0_q, s1_q, ts;
  logic signed [2*MB+2:0] qs_prod;
  logic [2*MB-1:0] prod_q;
  logic [DW-1:0]   run_mod_q, run_res_q, lcm_q;
  logic [PW-1:0]   mcand_q, acc_q, acc_nxt;
  logic [MB-1:0]   mplier_q;
  logic [MC_W-1:0] mcnt_q;
  logic            mul_last, ovf;

  logic [MB-1:0]   m_in, r_in;
  logic [MB:0]     c_sum, c_red;
  logic [SW-1:0]   s0_abs;
  logic [MB-1:0]   inv_calc;

  crt_pkg::div_req_t div_req;
  logic [DW-1:0]   div_dvd, div_quo;
  logic [MB-1:0]   div_dvs, div_rem;
  logic            div_done;
  logic            mul_start;
  logic [MB-1:0]   mul_val;

  crt_div #(
    .DIVISOR_BITS(MB)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (div_req),
    .dividend_i(div_dvd),
    .divisor_i (div_dvs),
    .done_o    (div_done),
    .quo_o     (div_quo),
    .rem_o     (div_rem)
  );

  // Handshake and input capture.
  assign in_stall_o = (state_q != crt_pkg::S_IDLE) || out_valid_q;
  assign accept     = in_valid_i && !in_stall_o;
  assign m_in = (modulus_i[IN_W-1:0] == '0) ? MB'(1) : MB'(modulus_i[IN_W-1:0]);
  assign r_in = MB'(residue_i[IN_W-1:0]);

  // Residue difference (r - run_residue) mod m, both operands below m.
  assign c_sum = {1'b0, r_q} + {1'b0, m_q} - {1'b0, div_rem};
  assign c_red = (c_sum >= {1'b0, m_q}) ? (c_sum - {1'b0, m_q}) : c_sum;

  // Euclid coefficient update.
  assign qs_prod = $signed({1'b0, q_q}) * s1_q;
  assign ts      = s0_q - qs_prod[SW-1:0];

  // Inverse from the signed coefficient: |coef| mod s, fixed up when negative.
  assign s0_abs   = s0_q[SW-1] ? SW'(-s0_q) : SW'(s0_q);
  assign inv_calc = (s0_q[SW-1] && (div_rem != '0)) ? (s_q - div_rem) : div_rem;

  // Shift-add multiplier with the running modulus as multiplicand.
  assign acc_nxt  = acc_q + (mplier_q[0] ? mcand_q : '0);
  assign mul_last = mcnt_q == MC_W'(MB - 1);
  assign ovf      = acc_nxt[PW-1:DW] != '0;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      crt_pkg::S_IDLE:   if (accept) state_d = crt_pkg::S_RED;
      crt_pkg::S_RED: begin
        if (div_done) begin
          if (first_q || (status_q != crt_pkg::ST_OK)) state_d = crt_pkg::S_IDLE;
          else state_d = crt_pkg::S_AMOD;
        end
      end
      crt_pkg::S_AMOD:   if (div_done) state_d = crt_pkg::S_RMOD;
      crt_pkg::S_RMOD:   if (div_done) state_d = crt_pkg::S_EU_CHK;
      crt_pkg::S_EU_CHK: state_d = (r1_q == '0) ? crt_pkg::S_CDIV : crt_pkg::S_EU_DIV;
      crt_pkg::S_EU_DIV: if (div_done) state_d = crt_pkg::S_EU_MUL;
      crt_pkg::S_EU_MUL: state_d = crt_pkg::S_EU_CHK;
      crt_pkg::S_CDIV: begin
        if (div_done) state_d = (div_rem != '0) ? crt_pkg::S_IDLE : crt_pkg::S_SDIV;
      end
      crt_pkg::S_SDIV:   if (div_done) state_d = crt_pkg::S_LCM;
      crt_pkg::S_LCM:    if (mul_last) state_d = ovf ? crt_pkg::S_IDLE : crt_pkg::S_INV;
      crt_pkg::S_INV:    if (div_done) state_d = crt_pkg::S_TMUL;
      crt_pkg::S_TMUL:   state_d = crt_pkg::S_TSTART;
      crt_pkg::S_TSTART: state_d = crt_pkg::S_TDIV;
      crt_pkg::S_TDIV:   if (div_done) state_d = crt_pkg::S_RES;
      crt_pkg::S_RES:    if (mul_last) state_d = crt_pkg::S_IDLE;
      default:           state_d = crt_pkg::S_IDLE;
    endcase
  end

  // Divider and multiplier requests, and the end of an item.
  always_comb begin
    div_req.start = 1'b0;
    div_req.nbits = CW'(MB);
    div_dvd       = '0;
    div_dvs       = m_q;
    mul_start     = 1'b0;
    mul_val       = div_quo[MB-1:0];
    fin           = 1'b0;
    unique case (state_q)
      crt_pkg::S_IDLE: begin
        div_req.start = accept;
        div_dvd       = DW'(r_in);
        div_dvs       = m_in;
      end
      crt_pkg::S_RED: begin
        if (div_done) begin
          if (first_q || (status_q != crt_pkg::ST_OK)) begin
            fin = 1'b1;
          end else begin
            div_req.start = 1'b1;
            div_req.nbits = CW'(DW);
            div_dvd       = run_mod_q;
          end
        end
      end
      crt_pkg::S_AMOD: begin
        div_req.start = div_done;
        div_req.nbits = CW'(DW);
        div_dvd       = run_res_q;
      end
      crt_pkg::S_EU_CHK: begin
        div_req.start = 1'b1;
        if (r1_q == '0) begin
          div_dvd = DW'(c_q);
          div_dvs = r0_q;
        end else begin
          div_dvd = DW'(r0_q);
          div_dvs = r1_q;
        end
      end
      crt_pkg::S_CDIV: begin
        if (div_done) begin
          if (div_rem != '0) begin
            fin = 1'b1;
          end else begin
            div_req.start = 1'b1;
            div_dvd       = DW'(m_q);
            div_dvs       = r0_q;
          end
        end
      end
      crt_pkg::S_SDIV: mul_start = div_done;
      crt_pkg::S_LCM: begin
        if (mul_last) begin
          if (ovf) begin
            fin = 1'b1;
          end else begin
            div_req.start = 1'b1;
            div_req.nbits = CW'(MB + 1);
            div_dvd       = DW'(s0_abs[MB:0]);
            div_dvs       = s_q;
          end
        end
      end
      crt_pkg::S_TSTART: begin
        div_req.start = 1'b1;
        div_req.nbits = CW'(2 * MB);
        div_dvd       = DW'(prod_q);
        div_dvs       = s_q;
      end
      crt_pkg::S_TDIV: begin
        mul_start = div_done;
        mul_val   = div_rem;
      end
      crt_pkg::S_RES: fin = mul_last;
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= crt_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      status_q    <= crt_pkg::ST_OK;
      run_mod_q   <= DW'(1);
      run_res_q   <= '0;
    end else begin
      state_q <= state_d;
      if (fin) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if ((state_q == crt_pkg::S_RED) && div_done && first_q) begin
        run_mod_q <= DW'(m_q);
        run_res_q <= DW'(div_rem);
        status_q  <= crt_pkg::ST_OK;
      end
      if ((state_q == crt_pkg::S_CDIV) && div_done && (div_rem != '0)) begin
        status_q <= crt_pkg::ST_NOSOL;
      end
      if ((state_q == crt_pkg::S_LCM) && mul_last && ovf) status_q <= crt_pkg::ST_OVF;
      if ((state_q == crt_pkg::S_RES) && mul_last) begin
        run_res_q <= run_res_q + acc_nxt[DW-1:0];
        run_mod_q <= lcm_q;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      m_q     <= m_in;
      first_q <= first_item_i;
    end
    if (mul_start) begin
      acc_q    <= '0;
      mcand_q  <= PW'(run_mod_q);
      mplier_q <= mul_val;
      mcnt_q   <= '0;
    end else if ((state_q == crt_pkg::S_LCM) || (state_q == crt_pkg::S_RES)) begin
      acc_q    <= acc_nxt;
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
      mcnt_q   <= mcnt_q + 1'b1;
    end
    unique case (state_q)
      crt_pkg::S_RED: if (div_done) r_q <= div_rem;
      crt_pkg::S_AMOD: begin
        if (div_done) begin
          r0_q <= div_rem;
          r1_q <= m_q;
          s0_q <= SW'(1);
          s1_q <= '0;
        end
      end
      crt_pkg::S_RMOD:   if (div_done) c_q <= c_red[MB-1:0];
      crt_pkg::S_EU_DIV: begin
        if (div_done) begin
          q_q  <= div_quo[MB-1:0];
          tr_q <= div_rem;
        end
      end
      crt_pkg::S_EU_MUL: begin
        r0_q <= r1_q;
        r1_q <= tr_q;
        s0_q <= s1_q;
        s1_q <= ts;
      end
      crt_pkg::S_CDIV:   if (div_done) cq_q <= div_quo[MB-1:0];
      crt_pkg::S_SDIV:   if (div_done) s_q <= div_quo[MB-1:0];
      crt_pkg::S_LCM:    if (mul_last) lcm_q <= acc_nxt[DW-1:0];
      crt_pkg::S_INV:    if (div_done) inv_q <= inv_calc;
      crt_pkg::S_TMUL:   prod_q <= cq_q * inv_q;
      default: ;
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign merged_residue_o = run_res_q;
  assign merged_modulus_o = run_mod_q;
  assign status_o         = status_q;

  `include "crt_congruence_merge_macros.svh"

  `ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, accept, state_q != crt_pkg::S_IDLE)
  `ASSERT_IMPLY(a_mod_nonzero, clk_i, rst_ni, 1'b1, run_mod_q != '0)
  `ASSERT_IMPLY(a_out_idle, clk_i, rst_ni, out_valid_o, state_q == crt_pkg::S_IDLE)

endmodule

// ===== design/crt_div.sv =====
// ----------------------------------------------------------------------------
// Serial restoring divider
// One quotient bit per cycle over a dividend of a selectable number of bits.
// ----------------------------------------------------------------------------
module crt_div #(
  parameter int DIVISOR_BITS = crt_pkg::MODULUS_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  crt_pkg::div_req_t          req_i,
  input  logic [crt_pkg::DATA_W-1:0] dividend_i,
  input  logic [DIVISOR_BITS-1:0]    divisor_i,
  output logic                       done_o,
  output logic [crt_pkg::DATA_W-1:0] quo_o,
  output logic [DIVISOR_BITS-1:0]    rem_o
);

  localparam int DW = crt_pkg::DATA_W;
  localparam int CW = crt_pkg::CNT_W;

  logic                  busy_q, done_q;
  logic [CW-1:0]         cnt_q;
  logic [DW-1:0]         quo_q;
  logic [DIVISOR_BITS-1:0] rem_q, dvs_q;
  logic [DIVISOR_BITS:0] trial, diff;
  logic                  ge;
  logic [CW-1:0]         shamt;

  assign trial = {rem_q, quo_q[DW-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};
  assign shamt = CW'(DW) - req_i.nbits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.nbits;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= dividend_i << shamt;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DW-2:0], ge};
      rem_q <= ge ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Congruence merge testbench
// Sends congruences through the valid/stall input channel, predicts each
// running congruence with a local generalized CRT model and checks every
// result transfer field by field. Both channel sides idle at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam longint unsigned MAX63 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int LIMIT_CYCLES = 10_000_000;

  typedef struct packed {
    logic [crt_pkg::FIELD_W-1:0] modulus;
    logic [crt_pkg::FIELD_W-1:0] residue;
    logic                        first_item;
  } congruence_t;

  typedef struct packed {
    logic [crt_pkg::DATA_W-1:0] residue;
    logic [crt_pkg::DATA_W-1:0] modulus;
    crt_pkg::status_e           status;
  } merged_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [crt_pkg::FIELD_W-1:0] modulus_i = '0;
  logic [crt_pkg::FIELD_W-1:0] residue_i = '0;
  logic first_item_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b1;
  logic [crt_pkg::DATA_W-1:0] merged_residue_o;
  logic [crt_pkg::DATA_W-1:0] merged_modulus_o;
  logic [1:0] status_o;

  crt_congruence_merge u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .modulus_i, .residue_i,
    .first_item_i, .out_valid_o, .out_stall_i, .merged_residue_o,
    .merged_modulus_o, .status_o
  );

  always #6 clk_i = ~clk_i;

  congruence_t pending_q[$];
  merged_t     expected_q[$];
  int          sender_idle_pct = 29;
  int          receiver_idle_pct = 57;
  int          hold_cycles = 0;
  bit          in_taken = 1'b0;
  int          mismatches = 0;
  longint      cycles = 0;

  // Running congruence of the predictor.
  longint unsigned  run_mod = 1;
  longint unsigned  run_res = 0;
  crt_pkg::status_e run_stat = crt_pkg::ST_OK;

  // Extended Euclid; returns gcd(a, b) and the coefficient of a.
  function automatic longint unsigned gcd_with_coef(longint unsigned a,
                                                    longint unsigned b,
                                                    output longint coef);
    longint r0, r1, s0, s1, q, tr, ts;
    r0 = a; r1 = b; s0 = 1; s1 = 0;
    while (r1 != 0) begin
      q = r0 / r1;
      tr = r0 - q * r1;
      ts = s0 - q * s1;
      r0 = r1; r1 = tr;
      s0 = s1; s1 = ts;
    end
    coef = s0;
    return r0;
  endfunction

  // Folds one congruence into the running one and returns the new state.
  function automatic merged_t merge_congruence(congruence_t c);
    longint unsigned m, r, a, g, diff, s, inv, t;
    longint coef;
    merged_t res;
    m = c.modulus;
    r = c.residue;
    if (m == 0) m = 1;
    r = r % m;
    if (c.first_item) begin
      run_mod = m; run_res = r; run_stat = crt_pkg::ST_OK;
    end else if (run_stat == crt_pkg::ST_OK) begin
      a = run_mod % m;
      g = gcd_with_coef(a, m, coef);
      diff = (r + m - (run_res % m)) % m;
      if (diff % g != 0) begin
        run_stat = crt_pkg::ST_NOSOL;
      end else begin
        s = m / g;
        if (run_mod > MAX63 / s) begin
          run_stat = crt_pkg::ST_OVF;
        end else begin
          inv = longint'(((coef % longint'(s)) + longint'(s)) % longint'(s));
          t = (((diff / g) % s) * inv) % s;
          run_res = run_res + t * run_mod;
          run_mod = run_mod * s;
        end
      end
    end
    res.residue = run_res[crt_pkg::DATA_W-1:0];
    res.modulus = run_mod[crt_pkg::DATA_W-1:0];
    res.status  = run_stat;
    return res;
  endfunction

  function automatic congruence_t make_item(int unsigned m, int unsigned r, bit first);
    congruence_t c;
    c.modulus = m[crt_pkg::FIELD_W-1:0];
    c.residue = r[crt_pkg::FIELD_W-1:0];
    c.first_item = first;
    return c;
  endfunction

  // Records whether the item on the input was taken at this rising edge.
  always @(posedge clk_i) begin
    in_taken <= in_valid_i && !in_stall_o;
  end

  // Input driver: a new item is presented at the falling edge after the
  // previous one was transferred; a stalled item is held unchanged.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pending_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_valid_i   <= 1'b1;
        modulus_i    <= pending_q[0].modulus;
        residue_i    <= pending_q[0].residue;
        first_item_i <= pending_q[0].first_item;
        pending_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, and a long hold counted down here.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_stall_i <= (hold_cycles > 0) || ($urandom_range(99) < receiver_idle_pct);
      if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    end
  end

  // Monitor: predicts on each input transfer, checks each output transfer.
  always @(posedge clk_i) begin
    merged_t got;
    merged_t want;
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (in_valid_i && !in_stall_o) begin
        expected_q.push_back(merge_congruence(
          congruence_t'({modulus_i, residue_i, first_item_i})));
      end
      if (out_valid_o && !out_stall_i) begin
        got.residue = merged_residue_o;
        got.modulus = merged_modulus_o;
        got.status  = crt_pkg::status_e'(status_o);
        if (expected_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("Unexpected result transfer: %p", got);
        end else begin
          want = expected_q.pop_front();
          if (got != want) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) begin
              $display("Mismatch: expected res=%0d mod=%0d st=%0d, got res=%0d mod=%0d st=%0d",
                       want.residue, want.modulus, want.status,
                       got.residue, got.modulus, got.status);
            end
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Builds a system: a first item and follow-ups mostly derived from one hidden
  // solution, so that most merges succeed until the lcm grows too large.
  task automatic queue_system(int len);
    longint unsigned x;
    int unsigned m;
    x = {$urandom, $urandom};
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(3))
        0: m = $urandom_range(65535, 1);
        1: m = $urandom_range(64, 1);
        2: m = $urandom_range(1000, 2) * $urandom_range(60, 1);
        default: m = 1 << $urandom_range(15);
      endcase
      if (m > 65535) m = 65535;
      // Sometimes break consistency or use an unreduced residue.
      if ($urandom_range(15) == 0)
        pending_q.push_back(make_item(m, $urandom_range(65535), i == 0));
      else if ($urandom_range(7) == 0 && x % m + m <= 65535)
        pending_q.push_back(make_item(m, 32'(x % m + m), i == 0));
      else
        pending_q.push_back(make_item(m, 32'(x % m), i == 0));
    end
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_valid_i || expected_q.size() > 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic random_phase(int n);
    int sent;
    int len;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(9) == 0) begin
        pending_q.push_back(make_item($urandom_range(65535), $urandom_range(65535),
                                      $urandom_range(1)));
        sent++;
      end else begin
        len = $urandom_range(8, 1);
        queue_system(len);
        sent = sent + len;
      end
      while (pending_q.size() > 8) @(posedge clk_i);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: merge from reset state, extremes, zero modulus, no solution,
    // sticky status, overflow and recovery by a first item.
    pending_q.push_back(make_item(5, 3, 1'b0));
    pending_q.push_back(make_item(0, 65535, 1'b0));
    pending_q.push_back(make_item(65535, 65535, 1'b1));
    pending_q.push_back(make_item(65534, 65535, 1'b0));
    pending_q.push_back(make_item(4, 1, 1'b1));
    pending_q.push_back(make_item(6, 2, 1'b0));
    pending_q.push_back(make_item(7, 3, 1'b0));
    pending_q.push_back(make_item(6, 3, 1'b1));
    pending_q.push_back(make_item(4, 2, 1'b0));
    pending_q.push_back(make_item(9, 1, 1'b0));
    pending_q.push_back(make_item(1, 0, 1'b1));
    pending_q.push_back(make_item(65521, 12345, 1'b0));
    pending_q.push_back(make_item(65519, 54321, 1'b0));
    pending_q.push_back(make_item(65497, 0, 1'b0));
    pending_q.push_back(make_item(65479, 65478, 1'b0));
    pending_q.push_back(make_item(65449, 7, 1'b0));
    pending_q.push_back(make_item(3, 1, 1'b0));
    pending_q.push_back(make_item(0, 0, 1'b1));
    pending_q.push_back(make_item(16'hAAAA, 16'h5555, 1'b0));
    pending_q.push_back(make_item(16'h5555, 16'hAAAA, 1'b0));
    drain();

    // Long receiver hold while the sender keeps offering items.
    sender_idle_pct = 0;
    hold_cycles = 3000;
    queue_system(6);
    wait (hold_cycles == 0);
    drain();

    sender_idle_pct = 29; receiver_idle_pct = 57;
    random_phase(500);
    drain();
    sender_idle_pct = 57; receiver_idle_pct = 29;
    random_phase(500);
    drain();
    sender_idle_pct = 0; receiver_idle_pct = 0;
    random_phase(500);
    drain();

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/crt_pkg.sv
design/crt_div.sv
design/crt_congruence_merge.sv
dv/testbench.sv
